/* hdl/pts_pkg.sv */
// Shared widths, payload structs and multiply helpers for the point-to-triangle
// squared-distance pipeline. No dependencies; used by pts_div and the top level.
`default_nettype none

package pts_pkg;

    localparam int CW    = 16;          // coordinate width, signed Q8.8
    localparam int NF    = 12;          // coordinates per input word
    localparam int DW    = CW + 1;      // vertex differences
    localparam int PW    = 2 * DW - 1;  // product of two differences
    localparam int GW    = PW + 3;      // Gram terms, sum of three products
    localparam int GH    = GW / 2;      // half split of a Gram operand
    localparam int GC    = GH + 1;      // half with a sign bit
    localparam int HW    = GW + GC;     // partial product of a Gram pair
    localparam int SW    = 71;          // Gram products, S, T, Det
    localparam int TW    = SW + 1;      // S + T
    localparam int ZW    = 70;          // divisor magnitude
    localparam int EW    = GW + 2;      // edge sums, squared vertex distances
    localparam int XW    = EW;          // distance term before the quotient
    localparam int MC    = 4;           // chunks of the wide multiplicand
    localparam int MPW   = GC + EW;     // chunk partial product
    localparam int MQW   = MPW + GH + 1;
    localparam int YW    = 112;         // dividend
    localparam int QW    = 36;          // quotient bits
    localparam int FW    = 41;          // final difference
    localparam int OW    = 40;          // result width
    localparam int IN_W  = NF * CW;

    localparam logic [OW-1:0] SAT = {OW{1'b1}};

    typedef struct packed {
        logic signed [GW-1:0] a00;
        logic signed [GW-1:0] a11;
        logic signed [GW-1:0] b0;
        logic signed [GW-1:0] b1;
        logic signed [GW-1:0] cq;
        logic signed [EW-1:0] full0;
        logic signed [EW-1:0] full1;
        logic signed [EW-1:0] denom;
        logic signed [EW-1:0] na;
        logic signed [EW-1:0] nb;
    } t_gram;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [SW-1:0] ma;
        logic signed [EW-1:0] mb;
        logic signed [SW-1:0] mc;
        logic signed [EW-1:0] md;
        logic [ZW-1:0]        z;
        logic                 inner;
        logic                 degen;
    } t_sel;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic [ZW-1:0]        z;
        logic                 inner;
        logic                 degen;
    } t_pass;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic                 yneg;
        logic                 degen;
    } t_side;

    function automatic logic signed [PW-1:0] mul_d(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return $signed({{(PW-DW){a[DW-1]}}, a}) * $signed({{(PW-DW){b[DW-1]}}, b});
    endfunction

    function automatic logic signed [HW-1:0] mul_g(input logic signed [GW-1:0] a,
                                                  input logic signed [GC-1:0] c);
        return $signed({{(HW-GW){a[GW-1]}}, a}) * $signed({{(HW-GC){c[GC-1]}}, c});
    endfunction

    function automatic logic signed [MPW-1:0] mul_c(input logic signed [GC-1:0] c,
                                                   input logic signed [EW-1:0] b);
        return $signed({{(MPW-GC){c[GC-1]}}, c}) * $signed({{(MPW-EW){b[EW-1]}}, b});
    endfunction

endpackage

`default_nettype wire

/* hdl/pts_div.sv */
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
// Depends on pts_pkg for widths and the side struct.
`default_nettype none

module pts_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic [pts_pkg::YW-1:0]   i_num,
    input  wire logic [pts_pkg::ZW-1:0]   i_den,
    input  wire pts_pkg::t_side           i_side,
    output logic                          o_vld,
    output logic [pts_pkg::QW-1:0]        o_quo,
    output pts_pkg::t_side                o_side
);

    logic [pts_pkg::YW-1:0] r_rem  [pts_pkg::QW];
    logic [pts_pkg::ZW-1:0] r_den  [pts_pkg::QW];
    logic [pts_pkg::QW-1:0] r_quo  [pts_pkg::QW];
    pts_pkg::t_side         r_side [pts_pkg::QW];
    logic [pts_pkg::QW-1:0] r_vld;

    for (genvar k = 0; k < pts_pkg::QW; k++) begin : g_stg
        logic [pts_pkg::YW-1:0] w_rem;
        logic [pts_pkg::ZW-1:0] w_den;
        logic [pts_pkg::QW-1:0] w_quo;
        pts_pkg::t_side         w_side;
        logic                   w_vld;
        logic [pts_pkg::YW-1:0] w_dsh;
        logic                   w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        // Divisor aligned to the quotient bit this stage decides.
        assign w_dsh = {{(pts_pkg::YW-pts_pkg::ZW){1'b0}}, w_den} << (pts_pkg::QW - 1 - k);
        assign w_ge  = (w_rem >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_rem - w_dsh) : w_rem;
                r_den[k]  <= w_den;
                r_quo[k]  <= {w_quo[pts_pkg::QW-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end
    end

    assign o_vld  = r_vld[pts_pkg::QW-1];
    assign o_quo  = r_quo[pts_pkg::QW-1];
    assign o_side = r_side[pts_pkg::QW-1];

`ifndef NO_ASSERTIONS
    a_first_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_rem[0] <
            ({{(pts_pkg::YW-pts_pkg::ZW){1'b0}}, r_den[0]} << (pts_pkg::QW - 1)))
        else $error("divider remainder too large after the first step");
    a_last_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[pts_pkg::QW-1] |-> r_rem[pts_pkg::QW-1] <
            {{(pts_pkg::YW-pts_pkg::ZW){1'b0}}, r_den[pts_pkg::QW-1]})
        else $error("final remainder not below the divisor");
`endif

endmodule

`default_nettype wire

/* hdl/point_triangle_sq_distance.sv */
// Top level: squared distance from a query point to a triangle, fully pipelined.
// Depends on pts_pkg and pts_div.
//
//   Channel  Direction  Word contents (lowest bits first)
//   s_axis   in         vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z, query_x/y/z (16 b each)
//   m_axis   out        tdata: sq_distance (40 b); tuser: degenerate (1 b)
//
// One word is accepted every cycle while the pipeline advances; each word gives one result word
// after 13 arithmetic stages, 36 divider stages of one quotient bit each, and 2 output stages.
// The divider's one-bit-per-stage compare and subtract sets the latency.
// Reset is synchronous and active low and clears only the valid bits.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall on m_axis holds every stage in place and nothing is lost or repeated.
`default_nettype none

module point_triangle_sq_distance (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    // vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z
    input  wire logic [pts_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // sq_distance
    output logic [pts_pkg::OW-1:0]          m_axis_tdata,
    // degenerate
    output logic [0:0]                      m_axis_tuser
);

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [pts_pkg::DW-1:0] sx_c(
        input logic signed [pts_pkg::CW-1:0] x);
        return $signed({{(pts_pkg::DW-pts_pkg::CW){x[pts_pkg::CW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::GW-1:0] sx_pg(
        input logic signed [pts_pkg::PW-1:0] x);
        return $signed({{(pts_pkg::GW-pts_pkg::PW){x[pts_pkg::PW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::EW-1:0] sx_ge(
        input logic signed [pts_pkg::GW-1:0] x);
        return $signed({{(pts_pkg::EW-pts_pkg::GW){x[pts_pkg::GW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::SW-1:0] sx_gs(
        input logic signed [pts_pkg::GW-1:0] x);
        return $signed({{(pts_pkg::SW-pts_pkg::GW){x[pts_pkg::GW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::SW-1:0] sx_es(
        input logic signed [pts_pkg::EW-1:0] x);
        return $signed({{(pts_pkg::SW-pts_pkg::EW){x[pts_pkg::EW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::SW-1:0] sx_hs(
        input logic signed [pts_pkg::HW-1:0] x);
        return $signed({{(pts_pkg::SW-pts_pkg::HW){x[pts_pkg::HW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::TW-1:0] sx_st(
        input logic signed [pts_pkg::SW-1:0] x);
        return $signed({{(pts_pkg::TW-pts_pkg::SW){x[pts_pkg::SW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::MQW-1:0] sx_pq(
        input logic signed [pts_pkg::MPW-1:0] x);
        return $signed({{(pts_pkg::MQW-pts_pkg::MPW){x[pts_pkg::MPW-1]}}, x});
    endfunction

    function automatic logic signed [pts_pkg::YW-1:0] sx_qy(
        input logic signed [pts_pkg::MQW-1:0] x);
        return $signed({{(pts_pkg::YW-pts_pkg::MQW){x[pts_pkg::MQW-1]}}, x});
    endfunction

    // A vertex result: distance term only, no quotient.
    function automatic pts_pkg::t_sel sel_vertex(input logic signed [pts_pkg::EW-1:0] x);
        pts_pkg::t_sel r;
        r       = '0;
        r.x     = x;
        r.z     = {{(pts_pkg::ZW-1){1'b0}}, 1'b1};
        return r;
    endfunction

    // Closest point on an edge leaving A (AB with b0/a00, AC with b1/a11).
    function automatic pts_pkg::t_sel sel_from_a(input logic signed [pts_pkg::GW-1:0] b,
                                                 input logic signed [pts_pkg::GW-1:0] aa,
                                                 input logic signed [pts_pkg::GW-1:0] cq,
                                                 input logic signed [pts_pkg::EW-1:0] full);
        pts_pkg::t_sel r;
        logic signed [pts_pkg::EW-1:0] sm;
        sm = sx_ge(aa) + sx_ge(b);
        if (!b[pts_pkg::GW-1]) begin
            r = sel_vertex(sx_ge(cq));
        end else if (sm[pts_pkg::EW-1] || sm == '0) begin
            r = sel_vertex(full);
        end else begin
            r    = sel_vertex(sx_ge(cq));
            r.ma = sx_gs(b);
            r.mb = sx_ge(b);
            r.z  = {{(pts_pkg::ZW-pts_pkg::GW){1'b0}}, aa};
        end
        return r;
    endfunction

    // Closest point on edge BC, numerator measured from the start vertex.
    function automatic pts_pkg::t_sel sel_bc(input logic signed [pts_pkg::EW-1:0] n,
                                             input logic signed [pts_pkg::EW-1:0] denom,
                                             input logic signed [pts_pkg::EW-1:0] vs,
                                             input logic signed [pts_pkg::EW-1:0] ve);
        pts_pkg::t_sel r;
        if (n >= denom) begin
            r = sel_vertex(ve);
        end else begin
            r    = sel_vertex(vs);
            r.ma = sx_es(n);
            r.mb = n;
            r.z  = {{(pts_pkg::ZW-pts_pkg::EW){1'b0}}, denom};
        end
        return r;
    endfunction

    // Region classification on the unnormalized edge parameters S and T.
    function automatic pts_pkg::t_sel classify(input logic signed [pts_pkg::SW-1:0] s,
                                               input logic signed [pts_pkg::SW-1:0] t,
                                               input logic signed [pts_pkg::TW-1:0] st,
                                               input logic [pts_pkg::ZW-1:0]        det,
                                               input pts_pkg::t_gram                g);
        pts_pkg::t_sel r;
        logic le, sn, tn;
        le = (st <= $signed({{(pts_pkg::TW-pts_pkg::ZW){1'b0}}, det}));
        sn = s[pts_pkg::SW-1];
        tn = t[pts_pkg::SW-1];
        if (le) begin
            if (sn) begin
                if (tn && g.b0[pts_pkg::GW-1]) begin
                    r = sel_from_a(g.b0, g.a00, g.cq, g.full0);
                end else begin
                    r = sel_from_a(g.b1, g.a11, g.cq, g.full1);
                end
            end else if (tn) begin
                r = sel_from_a(g.b0, g.a00, g.cq, g.full0);
            end else if (det == '0) begin
                // Flat triangle: the interior divisor vanishes.
                r       = sel_vertex('0);
                r.degen = 1'b1;
            end else begin
                r       = sel_vertex(sx_ge(g.cq));
                r.ma    = s;
                r.mb    = sx_ge(g.b0);
                r.mc    = t;
                r.md    = sx_ge(g.b1);
                r.z     = det;
                r.inner = 1'b1;
            end
        end else if (sn) begin
            if (!g.na[pts_pkg::EW-1] && g.na != '0) begin
                r = sel_bc(g.na, g.denom, g.full1, g.full0);
            end else begin
                r = sel_from_a(g.b1, g.a11, g.cq, g.full1);
            end
        end else if (tn) begin
            if (!g.nb[pts_pkg::EW-1] && g.nb != '0) begin
                r = sel_bc(g.nb, g.denom, g.full0, g.full1);
            end else begin
                r = sel_from_a(g.b0, g.a00, g.cq, g.full0);
            end
        end else begin
            if (g.na[pts_pkg::EW-1] || g.na == '0) begin
                r = sel_vertex(g.full1);
            end else begin
                r = sel_bc(g.na, g.denom, g.full1, g.full0);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- control
    logic        w_en;
    logic [13:1] r_v;
    logic        r14_v;
    logic        r_out_vld;

    // A stage moves on whenever the output register is free or being drained.
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_vld;

    // ---------------------------------------------------------------- stage 1: differences
    logic signed [pts_pkg::CW-1:0] w_v [pts_pkg::NF];
    logic signed [pts_pkg::DW-1:0] n1_d [3], n1_e0 [3], n1_e1 [3];
    logic signed [pts_pkg::DW-1:0] r1_d [3], r1_e0 [3], r1_e1 [3];

    always_comb begin
        for (int i = 0; i < pts_pkg::NF; i++) begin
            w_v[i] = s_axis_tdata[i*pts_pkg::CW +: pts_pkg::CW];
        end
        for (int j = 0; j < 3; j++) begin
            n1_d[j]  = sx_c(w_v[j])     - sx_c(w_v[9+j]);
            n1_e0[j] = sx_c(w_v[3+j])   - sx_c(w_v[j]);
            n1_e1[j] = sx_c(w_v[6+j])   - sx_c(w_v[j]);
        end
    end

    // ---------------------------------------------------------------- stage 2: coordinate products
    logic signed [pts_pkg::PW-1:0] r2_aa [3], r2_ab [3], r2_bb [3];
    logic signed [pts_pkg::PW-1:0] r2_d0 [3], r2_d1 [3], r2_dd [3];

    // ---------------------------------------------------------------- stage 3: Gram terms
    logic signed [pts_pkg::GW-1:0] r3_a00, r3_a01, r3_a11, r3_b0, r3_b1, r3_cq;

    // ---------------------------------------------------------------- stage 4: half products
    // Products: a00*a11, a01*a01, a01*b1, a11*b0, a01*b0, a00*b1.
    logic signed [pts_pkg::GW-1:0] w_aop [6], w_bop [6];
    logic signed [pts_pkg::HW-1:0] r4_pl [6], r4_ph [6];
    pts_pkg::t_gram                n4_g, r4_g;

    always_comb begin
        w_aop[0] = r3_a00; w_bop[0] = r3_a11;
        w_aop[1] = r3_a01; w_bop[1] = r3_a01;
        w_aop[2] = r3_a01; w_bop[2] = r3_b1;
        w_aop[3] = r3_a11; w_bop[3] = r3_b0;
        w_aop[4] = r3_a01; w_bop[4] = r3_b0;
        w_aop[5] = r3_a00; w_bop[5] = r3_b1;

        n4_g.a00   = r3_a00;
        n4_g.a11   = r3_a11;
        n4_g.b0    = r3_b0;
        n4_g.b1    = r3_b1;
        n4_g.cq    = r3_cq;
        // Squared distances to B and to C.
        n4_g.full0 = sx_ge(r3_a00) + (sx_ge(r3_b0) <<< 1) + sx_ge(r3_cq);
        n4_g.full1 = sx_ge(r3_a11) + (sx_ge(r3_b1) <<< 1) + sx_ge(r3_cq);
        // Squared length of BC.
        n4_g.denom = sx_ge(r3_a00) - (sx_ge(r3_a01) <<< 1) + sx_ge(r3_a11);
        n4_g.na    = sx_ge(r3_a11) + sx_ge(r3_b1) - sx_ge(r3_a01) - sx_ge(r3_b0);
        n4_g.nb    = sx_ge(r3_a00) + sx_ge(r3_b0) - sx_ge(r3_a01) - sx_ge(r3_b1);
    end

    // ---------------------------------------------------------------- stages 5-7
    logic signed [pts_pkg::SW-1:0] r5_p [6];
    pts_pkg::t_gram                r5_g, r6_g, r7_g;
    logic signed [pts_pkg::SW-1:0] r6_det, r6_s, r6_t;
    logic signed [pts_pkg::SW-1:0] n7_abs;
    logic [pts_pkg::ZW-1:0]        r7_det;
    logic signed [pts_pkg::SW-1:0] r7_s, r7_t;
    logic signed [pts_pkg::TW-1:0] r7_st;

    assign n7_abs = r6_det[pts_pkg::SW-1] ? -r6_det : r6_det;

    // ---------------------------------------------------------------- stage 8: region select
    pts_pkg::t_sel r8_sel;

    // ---------------------------------------------------------------- stages 9-13: numerator
    logic signed [pts_pkg::MC*pts_pkg::GH-1:0] w_ma_x, w_mc_x;
    logic signed [pts_pkg::GC-1:0]             w_ca [pts_pkg::MC], w_cc [pts_pkg::MC];
    logic signed [pts_pkg::MPW-1:0]            r9_pa [pts_pkg::MC], r9_pc [pts_pkg::MC];
    pts_pkg::t_pass                            n9_ps, r9_ps, r10_ps, r11_ps, r12_ps;
    logic signed [pts_pkg::MQW-1:0]            r10_qa [2], r10_qc [2];
    logic signed [pts_pkg::YW-1:0]             r11_ya, r11_yc, r12_sum;
    logic [pts_pkg::YW-1:0]                    r13_ymag;
    logic [pts_pkg::ZW-1:0]                    r13_z;
    pts_pkg::t_side                            r13_side;

    always_comb begin
        w_ma_x = $signed({{(pts_pkg::MC*pts_pkg::GH-pts_pkg::SW){r8_sel.ma[pts_pkg::SW-1]}},
                          r8_sel.ma});
        w_mc_x = $signed({{(pts_pkg::MC*pts_pkg::GH-pts_pkg::SW){r8_sel.mc[pts_pkg::SW-1]}},
                          r8_sel.mc});
        for (int k = 0; k < pts_pkg::MC; k++) begin
            // Lower chunks are unsigned, the top chunk carries the sign.
            if (k == pts_pkg::MC - 1) begin
                w_ca[k] = $signed({w_ma_x[k*pts_pkg::GH + pts_pkg::GH - 1],
                                   w_ma_x[k*pts_pkg::GH +: pts_pkg::GH]});
                w_cc[k] = $signed({w_mc_x[k*pts_pkg::GH + pts_pkg::GH - 1],
                                   w_mc_x[k*pts_pkg::GH +: pts_pkg::GH]});
            end else begin
                w_ca[k] = $signed({1'b0, w_ma_x[k*pts_pkg::GH +: pts_pkg::GH]});
                w_cc[k] = $signed({1'b0, w_mc_x[k*pts_pkg::GH +: pts_pkg::GH]});
            end
        end
        n9_ps.x     = r8_sel.x;
        n9_ps.z     = r8_sel.z;
        n9_ps.inner = r8_sel.inner;
        n9_ps.degen = r8_sel.degen;
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_d[j]  <= n1_d[j];
                r1_e0[j] <= n1_e0[j];
                r1_e1[j] <= n1_e1[j];

                r2_aa[j] <= pts_pkg::mul_d(r1_e0[j], r1_e0[j]);
                r2_ab[j] <= pts_pkg::mul_d(r1_e0[j], r1_e1[j]);
                r2_bb[j] <= pts_pkg::mul_d(r1_e1[j], r1_e1[j]);
                r2_d0[j] <= pts_pkg::mul_d(r1_d[j],  r1_e0[j]);
                r2_d1[j] <= pts_pkg::mul_d(r1_d[j],  r1_e1[j]);
                r2_dd[j] <= pts_pkg::mul_d(r1_d[j],  r1_d[j]);
            end

            r3_a00 <= sx_pg(r2_aa[0]) + sx_pg(r2_aa[1]) + sx_pg(r2_aa[2]);
            r3_a01 <= sx_pg(r2_ab[0]) + sx_pg(r2_ab[1]) + sx_pg(r2_ab[2]);
            r3_a11 <= sx_pg(r2_bb[0]) + sx_pg(r2_bb[1]) + sx_pg(r2_bb[2]);
            r3_b0  <= sx_pg(r2_d0[0]) + sx_pg(r2_d0[1]) + sx_pg(r2_d0[2]);
            r3_b1  <= sx_pg(r2_d1[0]) + sx_pg(r2_d1[1]) + sx_pg(r2_d1[2]);
            r3_cq  <= sx_pg(r2_dd[0]) + sx_pg(r2_dd[1]) + sx_pg(r2_dd[2]);

            for (int k = 0; k < 6; k++) begin
                r4_pl[k] <= pts_pkg::mul_g(w_aop[k],
                                $signed({1'b0, w_bop[k][pts_pkg::GH-1:0]}));
                r4_ph[k] <= pts_pkg::mul_g(w_aop[k],
                                $signed({w_bop[k][pts_pkg::GW-1],
                                         w_bop[k][pts_pkg::GW-1:pts_pkg::GH]}));
                r5_p[k]  <= sx_hs(r4_pl[k]) + (sx_hs(r4_ph[k]) <<< pts_pkg::GH);
            end
            r4_g <= n4_g;
            r5_g <= r4_g;

            r6_det <= r5_p[0] - r5_p[1];
            r6_s   <= r5_p[2] - r5_p[3];
            r6_t   <= r5_p[4] - r5_p[5];
            r6_g   <= r5_g;

            r7_det <= n7_abs[pts_pkg::ZW-1:0];
            r7_s   <= r6_s;
            r7_t   <= r6_t;
            r7_st  <= sx_st(r6_s) + sx_st(r6_t);
            r7_g   <= r6_g;

            r8_sel <= classify(r7_s, r7_t, r7_st, r7_det, r7_g);

            for (int k = 0; k < pts_pkg::MC; k++) begin
                r9_pa[k] <= pts_pkg::mul_c(w_ca[k], r8_sel.mb);
                r9_pc[k] <= pts_pkg::mul_c(w_cc[k], r8_sel.md);
            end
            r9_ps <= n9_ps;

            r10_qa[0] <= sx_pq(r9_pa[0]) + (sx_pq(r9_pa[1]) <<< pts_pkg::GH);
            r10_qa[1] <= sx_pq(r9_pa[2]) + (sx_pq(r9_pa[3]) <<< pts_pkg::GH);
            r10_qc[0] <= sx_pq(r9_pc[0]) + (sx_pq(r9_pc[1]) <<< pts_pkg::GH);
            r10_qc[1] <= sx_pq(r9_pc[2]) + (sx_pq(r9_pc[3]) <<< pts_pkg::GH);
            r10_ps    <= r9_ps;

            r11_ya <= sx_qy(r10_qa[0]) + (sx_qy(r10_qa[1]) <<< (2 * pts_pkg::GH));
            r11_yc <= sx_qy(r10_qc[0]) + (sx_qy(r10_qc[1]) <<< (2 * pts_pkg::GH));
            r11_ps <= r10_ps;

            r12_sum <= r11_ya + r11_yc;
            r12_ps  <= r11_ps;

            // Inside the triangle the dividend is the negated sum.
            r13_ymag       <= r12_sum[pts_pkg::YW-1] ? -r12_sum : r12_sum;
            r13_side.yneg  <= r12_ps.inner ? (!r12_sum[pts_pkg::YW-1] && r12_sum != '0)
                                           : r12_sum[pts_pkg::YW-1];
            r13_side.x     <= r12_ps.x;
            r13_side.degen <= r12_ps.degen;
            r13_z          <= r12_ps.z;
        end
    end

    // ---------------------------------------------------------------- divider
    logic                   w_dv_vld;
    logic [pts_pkg::QW-1:0] w_dv_quo;
    pts_pkg::t_side         w_dv_side;

    pts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v[13]),
        .i_num   (r13_ymag),
        .i_den   (r13_z),
        .i_side  (r13_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // ---------------------------------------------------------------- final stages
    logic signed [pts_pkg::FW-1:0] w_xe, w_qe, r14_dif, w_mag;
    logic                          r14_degen;

    assign w_xe  = $signed({{(pts_pkg::FW-pts_pkg::XW){w_dv_side.x[pts_pkg::XW-1]}},
                            w_dv_side.x});
    assign w_qe  = $signed({{(pts_pkg::FW-pts_pkg::QW){1'b0}}, w_dv_quo});
    assign w_mag = r14_dif[pts_pkg::FW-1] ? -r14_dif : r14_dif;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r14_dif   <= w_dv_side.yneg ? (w_xe + w_qe) : (w_xe - w_qe);
            r14_degen <= w_dv_side.degen;
            if (r14_degen || w_mag[pts_pkg::FW-1]) begin
                m_axis_tdata <= pts_pkg::SAT;
            end else begin
                m_axis_tdata <= w_mag[pts_pkg::OW-1:0];
            end
            m_axis_tuser <= r14_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r14_v     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v       <= {r_v[12:1], s_axis_tvalid};
            r14_v     <= w_dv_vld;
            r_out_vld <= r14_v;
        end
    end

`ifndef NO_ASSERTIONS
    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == pts_pkg::SAT)
        else $error("degenerate result not saturated");
    a_degen_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] && r8_sel.degen |->
            r8_sel.ma == '0 && r8_sel.mc == '0 && r8_sel.z == {{(pts_pkg::ZW-1){1'b0}}, 1'b1})
        else $error("degenerate case must not feed the divider");
    a_inner_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] && r8_sel.inner |-> !r8_sel.degen && r8_sel.z != '0)
        else $error("interior case with zero divisor");
`endif

endmodule

`default_nettype wire
